FILE: hw/rtl/svj_pkg.sv
// Shared types and constants for the seeded velocity jitter block.
`default_nettype none

package svj_pkg;

    localparam int VEL_W   = 7;
    localparam int OFS_W   = 7;
    localparam int SEED_W  = 31;
    localparam int MD_W    = 6;
    localparam int GEN_W   = 32;
    localparam int CHUNK_W = 8;
    localparam int SPAN_W  = MD_W + 1;
    localparam int DELTA_W = 8;
    localparam int SUM_W   = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [GEN_W-1:0] GOLDEN_STEP = 32'h9e37_79b9;
    localparam logic [GEN_W-1:0] MIX_MUL_A   = 32'h85eb_ca6b;
    localparam logic [GEN_W-1:0] MIX_MUL_B   = 32'hc2b2_ae35;
    localparam logic [VEL_W-1:0] VEL_MAX       = 7'd127;
    localparam logic [VEL_W-1:0] VEL_BELOW_MAX = 7'd126;
    localparam logic [VEL_W-1:0] VEL_MIN       = 7'd1;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SEED      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_DELTA = 1'b1;

    localparam logic [SEED_W-1:0] SEED_RESET      = 31'd0;
    localparam logic [MD_W-1:0]   MAX_DELTA_RESET = 6'd1;

    // The 32-bit mixed word is reduced one byte per step, most significant first.
    localparam logic [1:0] DIV_FIRST = 2'd0;
    localparam logic [1:0] DIV_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_A,
        ST_MIX_B,
        ST_DIV,
        ST_FINISH
    } svj_state_t;

    typedef struct packed {
        logic       load_in;
        logic       mix_a;
        logic       mix_b;
        logic       div_step;
        logic [1:0] div_sel;
        logic       load_out;
    } svj_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/svj_rem.sv
// Iterative remainder unit: reduces eight dividend bits per step against a small divisor.
`default_nettype none

module svj_rem (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        clear,
    input  wire logic                        step,
    input  wire logic [svj_pkg::CHUNK_W-1:0] chunk,
    input  wire logic [svj_pkg::SPAN_W-1:0]  span,
    output logic      [svj_pkg::SPAN_W-1:0]  rem
);

    logic [svj_pkg::SPAN_W-1:0] rem_reg;
    logic [svj_pkg::SPAN_W-1:0] rem_next;
    logic [svj_pkg::SPAN_W:0]   acc;

    // Restoring reduction: the partial remainder stays below span, so one
    // shifted bit never needs more than one subtraction.
    always_comb begin
        acc = {1'b0, rem_reg};
        for (int i = svj_pkg::CHUNK_W - 1; i >= 0; i--) begin
            acc = {acc[svj_pkg::SPAN_W-1:0], chunk[i]};
            if (acc >= {1'b0, span}) begin
                acc = acc - {1'b0, span};
            end
        end
    end

    always_comb begin
        priority if (clear) begin
            rem_next = '0;
        end else if (step) begin
            rem_next = acc[svj_pkg::SPAN_W-1:0];
        end else begin
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

    assign rem = rem_reg;

`ifndef ASSERT_OFF
    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !clear |=> rem_reg < $past(span))
        else $error("remainder not reduced below divisor");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/svj_ctrl.sv
// Controller state machine: sequences state update, mixing, reduction and result hand-off.
`default_nettype none

module svj_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output svj_pkg::svj_cmd_t     cmd
);

    svj_pkg::svj_state_t state_reg;
    svj_pkg::svj_state_t state_next;
    logic [1:0]          div_cnt_reg;
    logic [1:0]          div_cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            svj_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = svj_pkg::ST_MIX_A;
                end
            end
            svj_pkg::ST_MIX_A: begin
                state_next = svj_pkg::ST_MIX_B;
            end
            svj_pkg::ST_MIX_B: begin
                state_next = svj_pkg::ST_DIV;
            end
            svj_pkg::ST_DIV: begin
                if (div_cnt_reg == svj_pkg::DIV_LAST) begin
                    state_next = svj_pkg::ST_FINISH;
                end
            end
            svj_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = svj_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = svj_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.div_sel  = div_cnt_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            svj_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            svj_pkg::ST_MIX_A: begin
                cmd.mix_a = 1'b1;
            end
            svj_pkg::ST_MIX_B: begin
                cmd.mix_b    = 1'b1;
                div_cnt_next = svj_pkg::DIV_FIRST;
            end
            svj_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 2'd1;
            end
            svj_pkg::ST_FINISH: begin
                cmd.load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= svj_pkg::ST_IDLE;
            div_cnt_reg   <= svj_pkg::DIV_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an untaken transfer");

    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == svj_pkg::ST_DIV && div_cnt_reg != svj_pkg::DIV_LAST
        |=> state_reg == svj_pkg::ST_DIV)
        else $error("reduction left before all bytes were processed");

    a_finish_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == svj_pkg::ST_FINISH && !out_valid_reg |=> out_valid_reg)
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/svj_dpath.sv
// Datapath: generator state, two-stage mixer, remainder unit and velocity clamp.
`default_nettype none

module svj_dpath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire svj_pkg::svj_cmd_t           cmd,
    input  wire logic                        first_note,
    input  wire logic [svj_pkg::VEL_W-1:0]   old_velocity,
    input  wire logic [svj_pkg::SEED_W-1:0]  seed,
    input  wire logic [svj_pkg::MD_W-1:0]    max_delta,
    output logic      [svj_pkg::VEL_W-1:0]   new_velocity,
    output logic      [svj_pkg::OFS_W-1:0]   applied_offset
);

    logic [svj_pkg::GEN_W-1:0]   gen_state_reg;
    logic [svj_pkg::GEN_W-1:0]   gen_state_next;
    logic [svj_pkg::GEN_W-1:0]   gen_base;
    logic [svj_pkg::VEL_W-1:0]   old_vel_reg;
    logic [svj_pkg::GEN_W-1:0]   mul_a_reg;
    logic [svj_pkg::GEN_W-1:0]   mul_b_reg;
    logic [svj_pkg::GEN_W-1:0]   mix_in_a;
    logic [svj_pkg::GEN_W-1:0]   mix_in_b;
    logic [svj_pkg::GEN_W-1:0]   mixed;
    logic [svj_pkg::CHUNK_W-1:0] chunk;
    logic [svj_pkg::SPAN_W-1:0]  span;
    logic [svj_pkg::SPAN_W-1:0]  rem;
    logic signed [svj_pkg::DELTA_W-1:0] delta_raw;
    logic signed [svj_pkg::DELTA_W-1:0] delta;
    logic signed [svj_pkg::SUM_W-1:0]   vel_sum;
    logic [svj_pkg::VEL_W-1:0]   vel_clamp;
    logic [svj_pkg::VEL_W-1:0]   vel_final;
    logic [svj_pkg::VEL_W-1:0]   new_vel_reg;
    logic [svj_pkg::OFS_W-1:0]   offset_reg;

    // A first note reloads the generator from the seed before it advances.
    assign gen_base       = first_note ? {1'b0, seed} : gen_state_reg;
    assign gen_state_next = cmd.load_in ? gen_base + svj_pkg::GOLDEN_STEP : gen_state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_state_reg <= '0;
        end else begin
            gen_state_reg <= gen_state_next;
        end
    end

    assign mix_in_a = gen_state_reg ^ (gen_state_reg >> 16);
    assign mix_in_b = mul_a_reg ^ (mul_a_reg >> 13);
    assign mixed    = mul_b_reg ^ (mul_b_reg >> 16);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            old_vel_reg <= old_velocity;
        end
        if (cmd.mix_a) begin
            mul_a_reg <= mix_in_a * svj_pkg::MIX_MUL_A;
        end
        if (cmd.mix_b) begin
            mul_b_reg <= mix_in_b * svj_pkg::MIX_MUL_B;
        end
    end

    always_comb begin
        unique case (cmd.div_sel)
            2'd0:    chunk = mixed[31:24];
            2'd1:    chunk = mixed[23:16];
            2'd2:    chunk = mixed[15:8];
            default: chunk = mixed[7:0];
        endcase
    end

    assign span = {max_delta, 1'b1};

    svj_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cmd.mix_b),
        .step    (cmd.div_step),
        .chunk   (chunk),
        .span    (span),
        .rem     (rem)
    );

    assign delta_raw = $signed({1'b0, rem}) - $signed({2'b00, max_delta});

    // A zero draw is pushed to +1 or -1 by the top bit of the mixed word.
    always_comb begin
        if (delta_raw == '0) begin
            delta = mixed[svj_pkg::GEN_W-1] ? 8'sd1 : -8'sd1;
        end else begin
            delta = delta_raw;
        end
    end

    assign vel_sum = $signed({2'b00, old_vel_reg}) + $signed({delta[svj_pkg::DELTA_W-1], delta});

    always_comb begin
        priority if (vel_sum < 9'sd1) begin
            vel_clamp = svj_pkg::VEL_MIN;
        end else if (vel_sum > 9'sd127) begin
            vel_clamp = svj_pkg::VEL_MAX;
        end else begin
            vel_clamp = vel_sum[svj_pkg::VEL_W-1:0];
        end
    end

    // When the clamp swallows the offset, the velocity still has to move.
    always_comb begin
        priority if (vel_clamp != old_vel_reg) begin
            vel_final = vel_clamp;
        end else if (old_vel_reg == svj_pkg::VEL_MAX) begin
            vel_final = svj_pkg::VEL_BELOW_MAX;
        end else begin
            vel_final = old_vel_reg + 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            new_vel_reg <= vel_final;
            offset_reg  <= delta[svj_pkg::OFS_W-1:0];
        end
    end

    assign new_velocity   = new_vel_reg;
    assign applied_offset = offset_reg;

`ifndef ASSERT_OFF
    a_offset_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> applied_offset != '0)
        else $error("zero offset delivered");

    a_velocity_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> new_velocity != $past(old_vel_reg) && new_velocity != '0)
        else $error("velocity unchanged or out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/seeded_velocity_jitter.sv
// Top level of the seeded velocity jitter block: ports, configuration registers, wiring.
// Usage:
//   Notes enter on the s_ stream: s_tdata carries old_velocity, s_tuser marks the
//   first note of a run, which reloads the generator from the seed register.
//   Each note yields exactly one result on the m_ stream with the varied velocity
//   and the offset that was drawn.
//   Configuration is a plain write port: index 0 is the seed, index 1 the largest
//   offset magnitude. Write it only while no note is in flight.
//   Sequencing: after the input transfer the note passes the mix A, mix B, reduction
//   and finish states before its result is registered. One note is in flight at a
//   time; each mixing multiply has its own state and the modulo reduction walks
//   the four bytes of the mixed word one byte per cycle.
//   A finished result sits in the output register; the next note is accepted
//   while it waits. If the receiver keeps m_tready low, the following note
//   stalls in its last stage until the output register is free.
//   Reset (aresetn low, synchronous) clears the generator state to zero, the seed
//   to zero, the offset limit to one, and drops any pending result.
`default_nettype none

module seeded_velocity_jitter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [6:0] old_velocity, [7] zero
    input  wire logic [svj_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [0] first_note
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [6:0] new_velocity, [13:7] applied_offset, [15:14] zero
    output logic      [svj_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  wire logic                              cfg_wen,
    input  wire logic [svj_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [svj_pkg::SEED_W-1:0]        cfg_wdata
);

    logic [svj_pkg::SEED_W-1:0] seed_reg;
    logic [svj_pkg::SEED_W-1:0] seed_next;
    logic [svj_pkg::MD_W-1:0]   max_delta_reg;
    logic [svj_pkg::MD_W-1:0]   max_delta_next;
    svj_pkg::svj_cmd_t          cmd;
    logic [svj_pkg::VEL_W-1:0]  new_velocity;
    logic [svj_pkg::OFS_W-1:0]  applied_offset;

    always_comb begin
        seed_next      = seed_reg;
        max_delta_next = max_delta_reg;
        if (cfg_wen) begin
            unique case (cfg_addr)
                svj_pkg::CFG_IDX_SEED:      seed_next      = cfg_wdata;
                svj_pkg::CFG_IDX_MAX_DELTA: max_delta_next = cfg_wdata[svj_pkg::MD_W-1:0];
                default:                    seed_next      = seed_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= svj_pkg::SEED_RESET;
            max_delta_reg <= svj_pkg::MAX_DELTA_RESET;
        end else begin
            seed_reg      <= seed_next;
            max_delta_reg <= max_delta_next;
        end
    end

    svj_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    svj_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .first_note     (s_tuser),
        .old_velocity   (s_tdata[svj_pkg::VEL_W-1:0]),
        .seed           (seed_reg),
        .max_delta      (max_delta_reg),
        .new_velocity   (new_velocity),
        .applied_offset (applied_offset)
    );

    assign m_tdata = {2'b00, applied_offset, new_velocity};

endmodule

`default_nettype wire
